/* hdl/running_median_two_heaps_core_assert.svh */
// ----------------------------------------------------------------------------
// Running median assertion macros
// Shared property forms for the running median block.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_TWO_HEAPS_CORE_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_CORE_ASSERT_SVH

// Same-cycle implication.
`define RMH_CHECK_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("running median check failed");

// Next-cycle implication.
`define RMH_CHECK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("running median check failed");

`endif

/* hdl/rmh_pkg.sv */
// ----------------------------------------------------------------------------
// Running median package
// Command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rmh_pkg;

    localparam int IN_W  = 32;
    localparam int MED_W = 33;
    localparam int CNT_W = 11;

    typedef struct packed {
        logic load;
        logic pu_key;
        logic pu_carry;
        logic sd_init;
        logic rd_l;
        logic rd_r;
        logic cap_l;
        logic sd_move;
        logic rd_p;
        logic pu_move;
        logic write_v;
        logic count_inc;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic zero;
        logic replace;
        logic l_in;
        logic r_in;
        logic sd_move;
        logic root;
        logic pu_move;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

/* hdl/rmh_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmh_ram #(
    parameter int W  = 32,
    parameter int D  = 512,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/rmh_ctrl.sv */
// ----------------------------------------------------------------------------
// Running median controller
// Sequences the replace, sift-down and sift-up steps of one insertion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rmh_ctrl
    import rmh_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_status i_st,
    output t_cmd         o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECIDE = 10'b0000000010,
        S_SD_RDL = 10'b0000000100,
        S_SD_RDR = 10'b0000001000,
        S_SD_CMP = 10'b0000010000,
        S_PUC    = 10'b0000100000,
        S_PU_RD  = 10'b0001000000,
        S_PU_CMP = 10'b0010000000,
        S_FIN    = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (i_st.full) begin
                    n_state = S_OUT;
                end else if (!i_st.zero && i_st.replace) begin
                    o_cmd.sd_init = 1'b1;
                    n_state       = S_SD_RDL;
                end else begin
                    o_cmd.pu_key = 1'b1;
                    n_state      = S_PU_RD;
                end
            end
            S_SD_RDL: begin
                if (i_st.l_in) begin
                    o_cmd.rd_l = 1'b1;
                    n_state    = S_SD_RDR;
                end else begin
                    o_cmd.write_v = 1'b1;
                    n_state       = S_PUC;
                end
            end
            S_SD_RDR: begin
                o_cmd.cap_l = 1'b1;
                o_cmd.rd_r  = i_st.r_in;
                n_state     = S_SD_CMP;
            end
            S_SD_CMP: begin
                if (i_st.sd_move) begin
                    o_cmd.sd_move = 1'b1;
                    n_state       = S_SD_RDL;
                end else begin
                    o_cmd.write_v = 1'b1;
                    n_state       = S_PUC;
                end
            end
            S_PUC: begin
                o_cmd.pu_carry = 1'b1;
                n_state        = S_PU_RD;
            end
            S_PU_RD: begin
                if (i_st.root) begin
                    o_cmd.write_v = 1'b1;
                    n_state       = S_FIN;
                end else begin
                    o_cmd.rd_p = 1'b1;
                    n_state    = S_PU_CMP;
                end
            end
            S_PU_CMP: begin
                if (i_st.pu_move) begin
                    o_cmd.pu_move = 1'b1;
                    n_state       = S_PU_RD;
                end else begin
                    o_cmd.write_v = 1'b1;
                    n_state       = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.count_inc = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* hdl/rmh_dpath.sv */
// ----------------------------------------------------------------------------
// Running median datapath
// Heap memories, top caches, sift index and compare logic, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "running_median_two_heaps_core_assert.svh"

module rmh_dpath
    import rmh_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic signed [IN_W-1:0]  i_sample,
    input  wire t_cmd                    i_cmd,
    output t_status                      o_st,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [MED_W-1:0]      o_median_doubled,
    output logic        [CNT_W-1:0]      o_sample_count,
    output logic                         o_full_res
);

    localparam int SB = SAMPLE_BITS;
    localparam int HD = (CAPACITY + 1) / 2;
    localparam int AW = (HD > 1) ? $clog2(HD) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (SB + 1 > MED_W) ? SB + 1 : MED_W;

    function automatic logic above(input logic is_max,
                                   input logic signed [SB-1:0] a,
                                   input logic signed [SB-1:0] b);
        return is_max ? (a > b) : (a < b);
    endfunction

    logic        [CW-1:0] r_count;
    logic                 r_rej;
    logic signed [SB-1:0] r_key, r_v, r_carry, r_cl;
    logic signed [SB-1:0] r_lo_top, r_up_top;
    logic        [AW-1:0] r_idx;
    logic        [AW:0]   r_lim;
    logic                 r_upper;
    logic                 r_has_r;
    logic                 r_ovalid;
    logic signed [MED_W-1:0] r_med;
    logic        [CNT_W-1:0] r_cnt;
    logic                    r_full;

    logic signed [SB-1:0] w_key, w_rd, w_cand, w_wd;
    logic        [SB-1:0] w_rd_lo, w_rd_up;
    logic        [AW+1:0] w_l, w_r;
    logic        [AW-1:0] w_p, w_raddr;
    logic        [CW:0]   w_half_up;
    logic                 w_pick_r, w_we, w_odd;
    logic signed [MW-1:0] w_a, w_b, w_sum;

    if (SB <= IN_W) begin : g_key_narrow
        assign w_key = i_sample[SB-1:0];
    end else begin : g_key_wide
        assign w_key = {{(SB-IN_W){1'b0}}, i_sample};
    end

    assign w_odd     = r_count[0];
    assign w_l       = ({2'b00, r_idx} << 1) + (AW+2)'(1);
    assign w_r       = w_l + (AW+2)'(1);
    assign w_p       = (r_idx - AW'(1)) >> 1;
    assign w_half_up = ({1'b0, r_count} + (CW+1)'(1)) >> 1;

    always_comb begin
        priority if (i_cmd.rd_l) begin
            w_raddr = w_l[AW-1:0];
        end else if (i_cmd.rd_r) begin
            w_raddr = w_r[AW-1:0];
        end else if (i_cmd.rd_p) begin
            w_raddr = w_p;
        end else begin
            w_raddr = r_idx;
        end
    end

    assign w_rd     = r_upper ? w_rd_up : w_rd_lo;
    assign w_pick_r = r_has_r && above(!r_upper, w_rd, r_cl);
    assign w_cand   = w_pick_r ? w_rd : r_cl;

    assign w_we = i_cmd.write_v | i_cmd.sd_move | i_cmd.pu_move;
    always_comb begin
        priority if (i_cmd.sd_move) begin
            w_wd = w_cand;
        end else if (i_cmd.pu_move) begin
            w_wd = w_rd;
        end else begin
            w_wd = r_v;
        end
    end

    rmh_ram #(.W(SB), .D(HD), .AW(AW)) u_lo_ram (
        .i_clk   (i_clk),
        .i_we    (w_we && !r_upper),
        .i_waddr (r_idx),
        .i_wdata (w_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_lo)
    );

    rmh_ram #(.W(SB), .D(HD), .AW(AW)) u_up_ram (
        .i_clk   (i_clk),
        .i_we    (w_we && r_upper),
        .i_waddr (r_idx),
        .i_wdata (w_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_up)
    );

    // twice the median of the held set
    assign w_a   = {{(MW-SB){r_lo_top[SB-1]}}, r_lo_top};
    assign w_b   = w_odd ? w_a : {{(MW-SB){r_up_top[SB-1]}}, r_up_top};
    assign w_sum = w_a + w_b;

    assign o_st.full     = r_rej;
    assign o_st.zero     = (r_count == '0);
    assign o_st.replace  = w_odd ? (r_key < r_lo_top) : (r_key > r_up_top);
    assign o_st.l_in     = (w_l < {1'b0, r_lim});
    assign o_st.r_in     = (w_r < {1'b0, r_lim});
    assign o_st.sd_move  = above(!r_upper, w_cand, r_v);
    assign o_st.root     = (r_idx == '0);
    assign o_st.pu_move  = above(!r_upper, r_v, w_rd);
    assign o_st.out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= w_key;
            r_rej <= (r_count >= CW'(CAPACITY));
        end
        if (i_cmd.sd_init) begin
            r_upper <= !w_odd;
            r_v     <= r_key;
            r_carry <= w_odd ? r_lo_top : r_up_top;
            r_idx   <= '0;
            r_lim   <= w_odd ? (AW+1)'(w_half_up) : (AW+1)'(r_count >> 1);
        end
        if (i_cmd.pu_key || i_cmd.pu_carry) begin
            r_upper <= w_odd;
            r_v     <= i_cmd.pu_carry ? r_carry : r_key;
            r_idx   <= AW'(r_count >> 1);
        end
        if (i_cmd.cap_l) begin
            r_cl    <= w_rd;
            r_has_r <= o_st.r_in;
        end
        if (i_cmd.sd_move) begin
            r_idx <= w_pick_r ? w_r[AW-1:0] : w_l[AW-1:0];
        end
        if (i_cmd.pu_move) begin
            r_idx <= w_p;
        end
        // keep the tops in step with writes to the root
        if (w_we && r_idx == '0) begin
            if (r_upper) begin
                r_up_top <= w_wd;
            end else begin
                r_lo_top <= w_wd;
            end
        end
        if (i_cmd.emit) begin
            r_med  <= o_st.zero ? '0 : w_sum[MED_W-1:0];
            r_cnt  <= CNT_W'(r_count);
            r_full <= r_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.count_inc) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_ovalid;
    assign o_median_doubled = r_med;
    assign o_sample_count   = r_cnt;
    assign o_full_res       = r_full;

    `RMH_CHECK_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `RMH_CHECK_IMP(a_emit_free, i_clk, i_rst_n, i_cmd.emit, !r_ovalid || !i_stall)
    `RMH_CHECK_NEXT(a_count_step, i_clk, i_rst_n, i_cmd.count_inc, r_count == $past(r_count) + CW'(1))

endmodule

`default_nettype wire

/* hdl/running_median_two_heaps_core.sv */
// ----------------------------------------------------------------------------
// Running median core
// Two-heap running median over signed samples, result per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall / i_sample: one sample per transfer.
//   Output channel o_valid / i_stall: o_median_doubled (twice the median),
//   o_sample_count and o_full_res, one result per input transfer.
//   A sample is taken only while the core is idle; o_stall is high for the
//   whole insertion. o_valid rises once the insertion is done: with no top
//   replaced, each sift-up level is a parent read, then compare and move;
//   a replaced top adds a sift-down, each level of it a read each for the
//   left and right child, then compare and move, set by the single read
//   port of each heap memory. The next sample is taken the cycle after the
//   result is loaded, so the core is through with one sample before it
//   takes the next.
//   Once CAPACITY samples are held, a sample is dropped and the result
//   carries o_full_res = 1.
//   The result sits in an output register; a stalled receiver holds it and
//   the core finishes the next insertion before it waits on the register.
//   Reset clears the sample count and the output valid; heap memory
//   contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module running_median_two_heaps_core
    import rmh_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic signed [IN_W-1:0] i_sample,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic signed [MED_W-1:0]     o_median_doubled,
    output logic        [CNT_W-1:0]     o_sample_count,
    output logic                        o_full_res
);

    t_cmd    w_cmd;
    t_status w_st;

    rmh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    rmh_dpath #(
        .CAPACITY    (CAPACITY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample         (i_sample),
        .i_cmd            (w_cmd),
        .o_st             (w_st),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_median_doubled (o_median_doubled),
        .o_sample_count   (o_sample_count),
        .o_full_res       (o_full_res)
    );

endmodule

`default_nettype wire
